// ===== rtl/core/nps_pkg.sv =====
// shared types, constants and codes for the nearest point search block
`default_nettype none
package nps_pkg;

  // store geometry
  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // field widths
  localparam int COORD_W  = 16;
  localparam int ENTRY_W  = 2 * COORD_W;
  localparam int DIFF_W   = COORD_W;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int DIST_W   = SQ_W + 1;
  localparam int ACT_W    = 2;
  localparam int STATUS_W = 2;

  // action codes
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // request beat
  typedef struct packed {
    logic [ACT_W-1:0]          action;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
  } req_t;

  // response beat
  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [IDX_W-1:0]          near_index;
    logic signed [COORD_W-1:0] near_x;
    logic signed [COORD_W-1:0] near_y;
    logic [DIST_W-1:0]         dist_sq;
  } rsp_t;

  // port of the point memory
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
  } store_req_t;

  // output of the distance pipeline
  typedef struct packed {
    logic                      valid;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic [SQ_W-1:0]           sx;
    logic [SQ_W-1:0]           sy;
  } dist_t;

endpackage
`default_nettype wire

// ===== rtl/core/nps_store.sv =====
// point memory: one write port, one registered read port
`default_nettype none
module nps_store
  import nps_pkg::*;
(
  input  wire logic               clk,
  input  wire store_req_t         req,
  output logic [ENTRY_W-1:0]      rdata
);

  logic [ENTRY_W-1:0] mem [MAX_POINTS];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/nps_dist.sv =====
// two-stage pipeline from a stored point to squared axis distances
`default_nettype none
module nps_dist
  import nps_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic [IDX_W-1:0]          in_idx,
  input  wire logic [ENTRY_W-1:0]        entry,
  input  wire logic signed [COORD_W-1:0] qx,
  input  wire logic signed [COORD_W-1:0] qy,
  output dist_t                          dout
);

  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic signed [COORD_W:0]   diff_x;
  logic signed [COORD_W:0]   diff_y;
  logic [COORD_W:0]          abs_x;
  logic [COORD_W:0]          abs_y;

  logic                      s1_valid;
  logic [IDX_W-1:0]          s1_idx;
  logic signed [COORD_W-1:0] s1_px;
  logic signed [COORD_W-1:0] s1_py;
  logic [DIFF_W-1:0]         s1_dx;
  logic [DIFF_W-1:0]         s1_dy;

  // absolute differences, which always fit in the coordinate width
  always_comb begin
    px     = entry[ENTRY_W-1:COORD_W];
    py     = entry[COORD_W-1:0];
    diff_x = {qx[COORD_W-1], qx} - {px[COORD_W-1], px};
    diff_y = {qy[COORD_W-1], qy} - {py[COORD_W-1], py};
    abs_x  = diff_x[COORD_W] ? (~diff_x + 1'b1) : diff_x;
    abs_y  = diff_y[COORD_W] ? (~diff_y + 1'b1) : diff_y;
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    s1_idx <= in_idx;
    s1_px  <= px;
    s1_py  <= py;
    s1_dx  <= abs_x[DIFF_W-1:0];
    s1_dy  <= abs_y[DIFF_W-1:0];
  end

  // stage 2 control
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= s1_valid;
    end
  end

  // stage 2: squares
  always_ff @(posedge clk) begin
    dout.idx <= s1_idx;
    dout.px  <= s1_px;
    dout.py  <= s1_py;
    dout.sx  <= s1_dx * s1_dx;
    dout.sy  <= s1_dy * s1_dy;
  end

endmodule
`default_nettype wire

// ===== rtl/core/nearest_point_search_2d_core.sv =====
// top level: command handling, scan sequencer, minimum tracking and output register
`default_nettype none
// Keeps up to 1024 signed Q8.8 points and answers nearest-point queries by squared
// distance, lowest index winning ties. Clear and append finish at acceptance, and their
// response passes through the result holding register, then the output register. A query
// over N stored points reads the point memory through its single read port, one entry per
// cycle, and its result takes the same path once the last entry is scored. One request is
// in work at a time; a finished response waits in the output register while the next
// request is taken. The memory needs no clearing after reset.
module nearest_point_search_2d_core
  import nps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;

  logic [1:0]                state;
  logic [CNT_W-1:0]          count;
  logic [IDX_W-1:0]          addr;
  logic [IDX_W-1:0]          last;
  logic [CNT_W-1:0]          count_dec;
  logic signed [COORD_W-1:0] qx;
  logic signed [COORD_W-1:0] qy;
  logic                      rd_valid;
  logic [IDX_W-1:0]          rd_idx;
  logic [ENTRY_W-1:0]        rdata;
  store_req_t                sreq;
  dist_t                     dres;
  logic [DIST_W-1:0]         dsum;
  logic                      take_new;
  logic [DIST_W-1:0]         best_d;
  logic [IDX_W-1:0]          best_idx;
  logic signed [COORD_W-1:0] best_x;
  logic signed [COORD_W-1:0] best_y;
  logic [DIST_W-1:0]         sel_d;
  logic [IDX_W-1:0]          sel_idx;
  logic signed [COORD_W-1:0] sel_x;
  logic signed [COORD_W-1:0] sel_y;
  rsp_t                      res;
  rsp_t                      acc_res;
  logic                      start_scan;
  logic                      res_pend;
  logic                      accept;
  logic                      out_free;

  // handshake
  assign req_stall = (state != S_IDLE) || res_pend;
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // last stored index
  assign count_dec = count - 1'b1;
  assign last      = count_dec[IDX_W-1:0];

  // memory port
  always_comb begin
    sreq.we    = accept && (req.action == ACT_APPEND) && (count != CNT_W'(MAX_POINTS));
    sreq.waddr = count[IDX_W-1:0];
    sreq.wdata = {req.pos_x, req.pos_y};
    sreq.raddr = addr;
  end

  // response of a beat that finishes at once, and scan start
  always_comb begin
    acc_res = '0;
    if ((req.action == ACT_APPEND) && (count == CNT_W'(MAX_POINTS))) begin
      acc_res.status = ST_FULL;
    end else if ((req.action == ACT_QUERY) && (count == '0)) begin
      acc_res.status = ST_EMPTY;
    end
  end

  assign start_scan = (req.action == ACT_QUERY) && (count != '0);

  nps_store u_store (
    .clk   (clk),
    .req   (sreq),
    .rdata (rdata)
  );

  nps_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rd_valid),
    .in_idx   (rd_idx),
    .entry    (rdata),
    .qx       (qx),
    .qy       (qy),
    .dout     (dres)
  );

  // running minimum, first entry always taken, strict less-than after
  always_comb begin
    dsum     = {1'b0, dres.sx} + {1'b0, dres.sy};
    take_new = (dres.idx == '0) || (dsum < best_d);
    sel_d    = take_new ? dsum     : best_d;
    sel_idx  = take_new ? dres.idx : best_idx;
    sel_x    = take_new ? dres.px  : best_x;
    sel_y    = take_new ? dres.py  : best_y;
  end

  always_ff @(posedge clk) begin
    if (dres.valid) begin
      best_d   <= sel_d;
      best_idx <= sel_idx;
      best_x   <= sel_x;
      best_y   <= sel_y;
    end
  end

  // query coordinates and read tags
  always_ff @(posedge clk) begin
    if (accept) begin
      qx <= req.pos_x;
      qy <= req.pos_y;
    end
    rd_idx <= addr;
  end

  // sequencer, store count and result holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      addr     <= '0;
      rd_valid <= 1'b0;
      res_pend <= 1'b0;
      res      <= '0;
    end else begin
      rd_valid <= (state == S_ISSUE);
      if (res_pend && out_free) begin
        res_pend <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res      <= acc_res;
            res_pend <= !start_scan;
            addr     <= '0;
            unique case (req.action)
              ACT_CLEAR: begin
                count <= '0;
              end
              ACT_APPEND: begin
                if (count != CNT_W'(MAX_POINTS)) begin
                  count <= count + 1'b1;
                end
              end
              ACT_QUERY: begin
                if (start_scan) begin
                  state <= S_ISSUE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_ISSUE: begin
          if (addr == last) begin
            state <= S_WAIT;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_WAIT: begin
          if (dres.valid && (dres.idx == last)) begin
            res.status     <= ST_OK;
            res.near_index <= sel_idx;
            res.near_x     <= sel_x;
            res.near_y     <= sel_y;
            res.dist_sq    <= sel_d;
            res_pend       <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_pend && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_pend && out_free) begin
      rsp <= res;
    end
  end

endmodule
`default_nettype wire

// ===== dv/nearest_point_search_2d_core_tb.sv =====
// testbench for the nearest point search core: directed and random actions checked beat by beat
`timescale 1ns / 1ps

module nearest_point_search_2d_core_tb;
  import nps_pkg::*;

  // the one action code with no meaning, the block answers it with zeros
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = ~COORD_MIN;
  localparam int IDLE_LIMIT   = 6000;
  localparam int DRAIN_CYCLES = 1100;
  localparam int MIX_ITEMS    = 200;

  // tracks the point store and the answers still owed by the block
  class nearest_point_scoreboard;
    logic signed [COORD_W-1:0] store_x [MAX_POINTS];
    logic signed [COORD_W-1:0] store_y [MAX_POINTS];
    int unsigned n_points;
    rsp_t        pending_answers [$];
    int unsigned mismatches;
    int unsigned n_checked, n_found, n_full, n_empty;

    function new();
      n_points   = 0;
      mismatches = 0;
      n_checked  = 0;
      n_found    = 0;
      n_full     = 0;
      n_empty    = 0;
    endfunction

    function logic [DIST_W-1:0] sq_distance(logic signed [COORD_W-1:0] ax,
                                            logic signed [COORD_W-1:0] ay,
                                            logic signed [COORD_W-1:0] bx,
                                            logic signed [COORD_W-1:0] by);
      longint dx, dy;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      return DIST_W'(dx * dx + dy * dy);
    endfunction

    // apply one accepted request to the store and queue the answer it owes
    function void note_request(req_t r);
      rsp_t              want;
      logic [DIST_W-1:0] d, best_d;
      int unsigned       best;
      want = '0;
      case (r.action)
        ACT_CLEAR: begin
          n_points    = 0;
          want.status = ST_OK;
        end
        ACT_APPEND: begin
          if (n_points >= MAX_POINTS) begin
            want.status = ST_FULL;
          end else begin
            store_x[n_points] = r.pos_x;
            store_y[n_points] = r.pos_y;
            n_points++;
            want.status = ST_OK;
          end
        end
        ACT_QUERY: begin
          if (n_points == 0) begin
            want.status = ST_EMPTY;
          end else begin
            // strict less-than keeps the lowest index among equal minima
            best   = 0;
            best_d = sq_distance(r.pos_x, r.pos_y, store_x[0], store_y[0]);
            for (int i = 1; i < n_points; i++) begin
              d = sq_distance(r.pos_x, r.pos_y, store_x[i], store_y[i]);
              if (d < best_d) begin
                best_d = d;
                best   = i;
              end
            end
            want.status     = ST_OK;
            want.near_index = IDX_W'(best);
            want.near_x     = store_x[best];
            want.near_y     = store_y[best];
            want.dist_sq    = best_d;
          end
        end
        default: ;
      endcase
      pending_answers.push_back(want);
    endfunction

    function void report(string what, rsp_t got, rsp_t want);
      mismatches++;
      if (mismatches <= 10)
        $display("%t %s: status %0d/%0d index %0d/%0d x %0d/%0d y %0d/%0d dist %0d/%0d (got/exp)",
                 $realtime, what, got.status, want.status, got.near_index, want.near_index,
                 got.near_x, want.near_x, got.near_y, want.near_y, got.dist_sq, want.dist_sq);
    endfunction

    // compare one accepted response beat with the oldest owed answer
    function void check_answer(rsp_t got);
      rsp_t want;
      n_checked++;
      if (pending_answers.size() == 0) begin
        report("response with nothing owed", got, '0);
        return;
      end
      want = pending_answers.pop_front();
      if (got.status !== want.status || got.near_index !== want.near_index ||
          got.near_x !== want.near_x || got.near_y !== want.near_y ||
          got.dist_sq !== want.dist_sq)
        report("response mismatch", got, want);
      if (want.status == ST_FULL) n_full++;
      if (want.status == ST_EMPTY) n_empty++;
      if (want.status == ST_OK && want.dist_sq != '0) n_found++;
    endfunction

    function int pending();
      return pending_answers.size();
    endfunction
  endclass

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b1;
  rsp_t rsp;

  nearest_point_scoreboard nearest_sb = new();
  bit req_burst = 1'b0;
  bit rsp_burst = 1'b0;
  int idle_cycles = 0;

  nearest_point_search_2d_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one request beat: random gap, then hold until taken
  task automatic send_request(input logic [ACT_W-1:0] act,
                              input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y);
    req_t beat;
    int   gap;
    beat.action = act;
    beat.pos_x  = x;
    beat.pos_y  = y;
    if ($urandom_range(0, 31) == 0) req_burst = !req_burst;
    gap = req_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= beat;
    do @(posedge clk); while (req_stall);
    nearest_sb.note_request(beat);
  endtask

  // extremes, full-range values, or a point close to the cluster center
  function automatic logic signed [COORD_W-1:0] pick_coord(
      input logic signed [COORD_W-1:0] center);
    case ($urandom_range(0, 7))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2, 3, 4: return COORD_W'($urandom);
      default: return center + COORD_W'($urandom_range(0, 15)) - COORD_W'(8);
    endcase
  endfunction

  // mostly clear / append / query sequences on small stores, some noise
  task automatic run_random_mix(input int target);
    int done, k, q, idx;
    logic [ACT_W-1:0] act;
    logic signed [COORD_W-1:0] cx, cy;
    done = 0;
    while (done < target) begin
      if ($urandom_range(0, 9) == 0) begin
        act = ACT_W'($urandom_range(0, 3));
        send_request(act, COORD_W'($urandom), COORD_W'($urandom));
        if (act != ACT_UNUSED) done++;
      end else begin
        if (nearest_sb.n_points > 40 || $urandom_range(0, 1) == 0) begin
          send_request(ACT_CLEAR, COORD_W'($urandom), COORD_W'($urandom));
          done++;
        end
        cx = COORD_W'($urandom);
        cy = COORD_W'($urandom);
        k = $urandom_range(0, 10);
        repeat (k) send_request(ACT_APPEND, pick_coord(cx), pick_coord(cy));
        done += k;
        q = $urandom_range(1, 4);
        repeat (q) begin
          if (nearest_sb.n_points > 0 && $urandom_range(0, 2) == 0) begin
            idx = $urandom_range(0, nearest_sb.n_points - 1);
            send_request(ACT_QUERY, nearest_sb.store_x[idx], nearest_sb.store_y[idx]);
          end else begin
            send_request(ACT_QUERY, pick_coord(cx), pick_coord(cy));
          end
          done++;
        end
      end
    end
  endtask

  // response side: random stall per beat, check every accepted beat
  initial begin
    int hold;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) rsp_burst = !rsp_burst;
      hold = rsp_burst ? 0 : $urandom_range(0, 18);
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
      nearest_sb.check_answer(rsp);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no beat for %0d cycles, %0d answers owed", idle_cycles, nearest_sb.pending());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    logic signed [COORD_W-1:0] last_x, last_y;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty store, unused code, extremes, ties, clear
    send_request(ACT_QUERY, COORD_MAX, COORD_MIN);
    send_request(ACT_UNUSED, COORD_MAX, COORD_MAX);
    send_request(ACT_APPEND, COORD_MIN, COORD_MIN);
    send_request(ACT_QUERY, COORD_MAX, COORD_MAX);
    send_request(ACT_APPEND, COORD_MAX, COORD_MAX);
    send_request(ACT_APPEND, COORD_MIN, COORD_MIN);
    send_request(ACT_QUERY, COORD_MIN, COORD_MIN);
    send_request(ACT_QUERY, COORD_MAX, COORD_MAX);
    send_request(ACT_APPEND, '0, '0);
    send_request(ACT_APPEND, '1, COORD_W'(1));
    send_request(ACT_QUERY, '0, '0);
    send_request(ACT_QUERY, '1, COORD_W'(1));
    send_request(ACT_QUERY, COORD_MAX, COORD_MIN);
    send_request(ACT_UNUSED, '0, '1);
    send_request(ACT_QUERY, '0, '1);
    send_request(ACT_CLEAR, COORD_MAX, COORD_MIN);
    send_request(ACT_QUERY, '0, '0);
    send_request(ACT_APPEND, COORD_W'(16'h0100), COORD_W'(16'hff00));
    send_request(ACT_QUERY, COORD_MIN, COORD_MAX);
    send_request(ACT_CLEAR, '1, '1);
    send_request(ACT_CLEAR, '0, '0);

    run_random_mix(MIX_ITEMS);

    // full store: fill, overflow appends, queries over every entry
    send_request(ACT_CLEAR, '0, '0);
    for (int i = 0; i < MAX_POINTS; i++) begin
      last_x = COORD_W'($urandom);
      last_y = COORD_W'($urandom);
      send_request(ACT_APPEND, last_x, last_y);
    end
    send_request(ACT_APPEND, COORD_MIN, COORD_MAX);
    send_request(ACT_APPEND, '0, '0);
    send_request(ACT_QUERY, last_x, last_y);
    send_request(ACT_QUERY, COORD_MIN, COORD_MAX);
    send_request(ACT_QUERY, COORD_W'($urandom), COORD_W'($urandom));
    send_request(ACT_UNUSED, last_x, last_y);
    send_request(ACT_APPEND, last_x, last_y);
    send_request(ACT_CLEAR, '0, '0);

    run_random_mix(MIX_ITEMS);
    req_valid <= 1'b0;

    // drain, then leave room for any stray response
    while (nearest_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d responses: %0d nonzero nearest answers, %0d full-store appends,",
             nearest_sb.n_checked, nearest_sb.n_found, nearest_sb.n_full);
    $display("%0d empty-store queries, %0d mismatches",
             nearest_sb.n_empty, nearest_sb.mismatches);
    if (nearest_sb.mismatches == 0 && nearest_sb.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/nps_pkg.sv
rtl/core/nps_store.sv
rtl/core/nps_dist.sv
rtl/core/nearest_point_search_2d_core.sv
dv/nearest_point_search_2d_core_tb.sv
